[rtl/binomial_tree_option_pricer_macros.svh]
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_macros: assertion macros of the pricer RTL
// Each macro expects clk and rst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_TREE_OPTION_PRICER_MACROS_SVH
`define BINOMIAL_TREE_OPTION_PRICER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BTOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/btop_pkg.sv]
// ----------------------------------------------------------------------------
// btop_pkg: shared types, constants and arithmetic for the binomial pricer
// Tree size, register codes, cell commands and the fixed-point helpers used
// by both the controller and the node cells.
// ----------------------------------------------------------------------------
package btop_pkg;

  localparam int MAX_STEPS = 256;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int WORD_W    = 32;
  localparam int STEPS_W   = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0]  UP_RST     = 32'h4000_0000;
  localparam logic [WORD_W-1:0]  DOWN_RST   = 32'h4000_0000;
  localparam logic [WORD_W-1:0]  PROB_RST   = 32'h8000_0000;
  localparam logic [WORD_W-1:0]  DISC_RST   = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0]  STRIKE_RST = 32'h0000_0000;
  localparam logic [STEPS_W-1:0] STEPS_RST  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP     = 3'd0,
    REG_DOWN   = 3'd1,
    REG_PROB   = 3'd2,
    REG_DISC   = 3'd3,
    REG_STRIKE = 3'd4,
    REG_STEPS  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAF,
    ST_PAYOFF,
    ST_MIX,
    ST_DISC,
    ST_DONE
  } fsm_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LEAF,
    OP_PAYOFF,
    OP_MIX,
    OP_DISC
  } cell_op_t;

  typedef struct packed {
    logic [WORD_W-1:0]  up;
    logic [WORD_W-1:0]  down;
    logic [WORD_W-1:0]  prob;
    logic [WORD_W-1:0]  disc;
    logic [WORD_W-1:0]  strike;
    logic [STEPS_W-1:0] steps;
  } cfg_t;

  // Broadcast to every cell of the row each cycle.
  typedef struct packed {
    cell_op_t           op;
    logic [WORD_W-1:0]  entry_val;
    logic [IDX_W-1:0]   last_idx;
    logic               put;
    logic [WORD_W-1:0]  down;
    logic [WORD_W-1:0]  prob;
    logic [WORD_W-1:0]  disc;
    logic [WORD_W-1:0]  strike;
  } cell_cmd_t;

  // price * factor in Q2.30, truncated, saturated to all ones.
  function automatic logic [WORD_W-1:0] scale_price(input logic [WORD_W-1:0] price,
                                                    input logic [WORD_W-1:0] factor);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(price) * (2*WORD_W)'(factor);
    if (prod[2*WORD_W-1:2*WORD_W-2] != 2'b00) begin
      return '1;
    end
    return prod[2*WORD_W-3:WORD_W-2];
  endfunction

  function automatic logic [WORD_W-1:0] payoff(input logic [WORD_W-1:0] s,
                                               input logic [WORD_W-1:0] k,
                                               input logic              put);
    if (put) begin
      return (k > s) ? (k - s) : '0;
    end
    return (s > k) ? (s - k) : '0;
  endfunction

endpackage

[rtl/btop_if.sv]
// ----------------------------------------------------------------------------
// btop_if: valid/ready channels of the binomial pricer
// Input word carries spot price and call/put mode; output word the root value.
// ----------------------------------------------------------------------------
interface btop_in_if;
  logic                        valid;
  logic                        ready;
  logic [btop_pkg::WORD_W-1:0] spot_price;
  logic                        mode;

  modport source (output valid, output spot_price, output mode, input ready);
  modport sink   (input valid, input spot_price, input mode, output ready);
endinterface

interface btop_out_if;
  logic                        valid;
  logic                        ready;
  logic [btop_pkg::WORD_W-1:0] option_price;

  modport source (output valid, output option_price, input ready);
  modport sink   (input valid, input option_price, output ready);
endinterface

[rtl/binomial_tree_option_pricer.sv]
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer: CRR European option pricer, fixed point
// A row of MAX_STEPS node cells builds leaf prices, takes the payoff and
// folds back to the root under a small sequencer.
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid/ready      | spot_price[31:0], mode
//   out_ch  | out | valid/ready      | option_price[31:0]
//   cfg_*   | in  | cfg_we, no wait  | cfg_index[2:0], cfg_wdata[31:0]
//
// An item passes through the accept step in idle, a leaf shift through the cell
// row for each of the n tree levels, the payoff step, a mix and then a discount
// step in each cell for each of the n-1 fold levels, and the load of the output
// register. One item is in the tree at a time; the next word is taken while the
// result word waits in the output register. Reset is synchronous, active low;
// it clears control state and the configuration registers only and needs no
// clearing pass over the cells.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer (
  input  logic                             clk,
  input  logic                             rst_n,
  btop_in_if.sink                          in_ch,
  btop_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [btop_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btop_pkg::WORD_W-1:0]      cfg_wdata
);

  btop_pkg::cfg_t       cfg_r;
  btop_pkg::cell_cmd_t  cmd;
  logic [btop_pkg::WORD_W-1:0] node_val [btop_pkg::MAX_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up     <= btop_pkg::UP_RST;
      cfg_r.down   <= btop_pkg::DOWN_RST;
      cfg_r.prob   <= btop_pkg::PROB_RST;
      cfg_r.disc   <= btop_pkg::DISC_RST;
      cfg_r.strike <= btop_pkg::STRIKE_RST;
      cfg_r.steps  <= btop_pkg::STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btop_pkg::REG_UP:     cfg_r.up     <= cfg_wdata;
        btop_pkg::REG_DOWN:   cfg_r.down   <= cfg_wdata;
        btop_pkg::REG_PROB:   cfg_r.prob   <= cfg_wdata;
        btop_pkg::REG_DISC:   cfg_r.disc   <= cfg_wdata;
        btop_pkg::REG_STRIKE: cfg_r.strike <= cfg_wdata;
        btop_pkg::REG_STEPS:  cfg_r.steps  <= cfg_wdata[btop_pkg::STEPS_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  btop_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_spot   (in_ch.spot_price),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_price (out_ch.option_price),
    .root_val  (node_val[0]),
    .cmd       (cmd)
  );

  // leaves enter at the last used cell and shift toward cell 0
  for (genvar c = 0; c < btop_pkg::MAX_STEPS; c++) begin : g_cell
    logic [btop_pkg::WORD_W-1:0] nbr;
    logic                        is_entry;

    if (c == btop_pkg::MAX_STEPS - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = node_val[c+1];
    end

    assign is_entry = (btop_pkg::IDX_W'(c) == cmd.last_idx);

    btop_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .is_entry (is_entry),
      .nbr_val  (nbr),
      .val      (node_val[c])
    );
  end

endmodule

[rtl/btop_cell.sv]
// ----------------------------------------------------------------------------
// btop_cell: one tree node of the systolic row
// Holds one node value; shifts down-scaled leaves from its upper neighbor,
// applies the payoff, and folds with its upper neighbor in two steps.
// ----------------------------------------------------------------------------
module btop_cell (
  input  logic                               clk,
  input  btop_pkg::cell_cmd_t                cmd,
  input  logic                               is_entry,
  input  logic [btop_pkg::WORD_W-1:0]        nbr_val,
  output logic [btop_pkg::WORD_W-1:0]        val
);

  logic [btop_pkg::WORD_W-1:0]   val_r;
  logic [btop_pkg::WORD_W-1:0]   val_nxt;
  logic [btop_pkg::WORD_W-1:0]   mix_r;
  logic [btop_pkg::WORD_W-1:0]   mix_nxt;
  logic signed [btop_pkg::WORD_W:0]     diff;
  logic signed [2*btop_pkg::WORD_W+1:0] wdiff;
  logic [2*btop_pkg::WORD_W-1:0] disc_prod;

  // mix = lo + floor(p * (hi - lo) / 2^32), same as the weighted sum
  assign diff      = $signed({1'b0, nbr_val}) - $signed({1'b0, val_r});
  assign wdiff     = $signed({1'b0, cmd.prob}) * diff;
  assign disc_prod = (2*btop_pkg::WORD_W)'(mix_r) * (2*btop_pkg::WORD_W)'(cmd.disc);

  always_comb begin
    val_nxt = val_r;
    mix_nxt = mix_r;
    unique case (cmd.op)
      btop_pkg::OP_HOLD: begin
      end
      btop_pkg::OP_LEAF: begin
        val_nxt = is_entry ? cmd.entry_val : btop_pkg::scale_price(nbr_val, cmd.down);
      end
      btop_pkg::OP_PAYOFF: begin
        val_nxt = btop_pkg::payoff(val_r, cmd.strike, cmd.put);
      end
      btop_pkg::OP_MIX: begin
        mix_nxt = val_r + wdiff[2*btop_pkg::WORD_W-1:btop_pkg::WORD_W];
      end
      btop_pkg::OP_DISC: begin
        val_nxt = disc_prod[2*btop_pkg::WORD_W-1:btop_pkg::WORD_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    mix_r <= mix_nxt;
  end

  assign val = val_r;

endmodule

[rtl/btop_ctrl.sv]
// ----------------------------------------------------------------------------
// btop_ctrl: sequencer of the binomial pricer
// Takes input words, generates the up-move price series, steps the cell row
// through leaf, payoff and fold phases, and holds the result word.
// ----------------------------------------------------------------------------
`include "binomial_tree_option_pricer_macros.svh"

module btop_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btop_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [btop_pkg::WORD_W-1:0]   in_spot,
  input  logic                          in_mode,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btop_pkg::WORD_W-1:0]   out_price,
  input  logic [btop_pkg::WORD_W-1:0]   root_val,
  output btop_pkg::cell_cmd_t           cmd
);

  btop_pkg::fsm_state_t          state_r, state_nxt;
  logic [btop_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [btop_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [btop_pkg::CNT_W-1:0]    n_eff;
  logic [btop_pkg::WORD_W-1:0]   pow_r, pow_nxt;
  logic                          put_r, put_nxt;
  logic [btop_pkg::WORD_W-1:0]   out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [btop_pkg::WORD_W-1:0]   entry_val;

  // clamp the step count to 1..MAX_STEPS
  always_comb begin
    if (cfg.steps == '0) begin
      n_eff = btop_pkg::CNT_W'(1);
    end else if (32'(cfg.steps) > btop_pkg::MAX_STEPS) begin
      n_eff = btop_pkg::CNT_W'(btop_pkg::MAX_STEPS);
    end else begin
      n_eff = btop_pkg::CNT_W'(cfg.steps);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    pow_nxt       = pow_r;
    put_nxt       = put_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    entry_val     = pow_r;
    cmd.op        = btop_pkg::OP_HOLD;
    unique case (state_r)
      btop_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pow_nxt   = in_spot;
          put_nxt   = in_mode;
          n_nxt     = n_eff;
          cnt_nxt   = '0;
          state_nxt = btop_pkg::ST_LEAF;
        end
      end
      btop_pkg::ST_LEAF: begin
        cmd.op = btop_pkg::OP_LEAF;
        // first leaf enters at spot, later ones one more up move each
        if (cnt_r != '0) begin
          entry_val = btop_pkg::scale_price(pow_r, cfg.up);
        end
        pow_nxt = entry_val;
        if (btop_pkg::CNT_W'(cnt_r) == n_r - btop_pkg::CNT_W'(1)) begin
          state_nxt = btop_pkg::ST_PAYOFF;
        end else begin
          cnt_nxt = cnt_r + btop_pkg::IDX_W'(1);
        end
      end
      btop_pkg::ST_PAYOFF: begin
        cmd.op  = btop_pkg::OP_PAYOFF;
        cnt_nxt = '0;
        if (n_r == btop_pkg::CNT_W'(1)) begin
          state_nxt = btop_pkg::ST_DONE;
        end else begin
          state_nxt = btop_pkg::ST_MIX;
        end
      end
      btop_pkg::ST_MIX: begin
        cmd.op    = btop_pkg::OP_MIX;
        state_nxt = btop_pkg::ST_DISC;
      end
      btop_pkg::ST_DISC: begin
        cmd.op = btop_pkg::OP_DISC;
        if (btop_pkg::CNT_W'(cnt_r) + btop_pkg::CNT_W'(2) == n_r) begin
          state_nxt = btop_pkg::ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + btop_pkg::IDX_W'(1);
          state_nxt = btop_pkg::ST_MIX;
        end
      end
      btop_pkg::ST_DONE: begin
        // hold the root until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_nxt       = root_val;
          out_valid_nxt = 1'b1;
          state_nxt     = btop_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = btop_pkg::ST_IDLE;
      end
    endcase
    cmd.entry_val = entry_val;
    cmd.last_idx  = btop_pkg::IDX_W'(n_r - btop_pkg::CNT_W'(1));
    cmd.put       = put_r;
    cmd.down      = cfg.down;
    cmd.prob      = cfg.prob;
    cmd.disc      = cfg.disc;
    cmd.strike    = cfg.strike;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btop_pkg::ST_IDLE;
      cnt_r       <= '0;
      n_r         <= btop_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r <= pow_nxt;
    put_r <= put_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_price = out_r;

  `BTOP_ASSERT_NXT(a_accept_starts_leaf, in_valid && in_ready,
    state_r == btop_pkg::ST_LEAF && cnt_r == '0, "accepted word did not start leaf phase")
  `BTOP_ASSERT_IMP(a_leaf_in_range, state_r == btop_pkg::ST_LEAF,
    btop_pkg::CNT_W'(cnt_r) < n_r, "leaf counter past last leaf")
  `BTOP_ASSERT_NXT(a_disc_next, state_r == btop_pkg::ST_DISC,
    state_r == btop_pkg::ST_MIX || state_r == btop_pkg::ST_DONE, "fold step left sequence")
  `BTOP_ASSERT_IMP(a_out_from_done, $rose(out_valid_r),
    $past(state_r) == btop_pkg::ST_DONE, "result word raised outside done")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for binomial_tree_option_pricer
// Drives spot/mode words with random gaps, stalls the result channel at random
// and compares every root value with a bit-true fixed-point tree built here.
// Registers change only between phases while the tree is empty; the run steps
// through edge settings (zero and full-scale factors, step counts 0, 1 and
// above the tree size) and then through randomized market setups.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_NS          = 4_000_000;
  localparam int RECV_HOLD_CYCLES  = 1500;
  localparam int RANDOM_QUOTES     = 410;
  localparam int PRESSURE_QUOTES   = 14;
  localparam int END_WAIT          = 3 * btop_pkg::MAX_STEPS + 16;

  localparam logic [btop_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [btop_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic MODE_CALL = 1'b0;
  localparam logic MODE_PUT  = 1'b1;

  typedef struct {
    logic [btop_pkg::WORD_W-1:0] spot;
    logic                        put;
  } quote_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [btop_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [btop_pkg::WORD_W-1:0]    cfg_wdata;

  btop_in_if  in_if ();
  btop_out_if out_if ();

  binomial_tree_option_pricer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  btop_pkg::cfg_t              market;
  quote_t                      quote_queue[$];
  logic [btop_pkg::WORD_W-1:0] price_expect[$];
  logic [btop_pkg::WORD_W-1:0] expected_price;
  quote_t                      next_quote;
  int                quotes_sent  = 0;
  int                prices_seen  = 0;
  int                fail_count   = 0;
  int                send_gap     = 0;
  int                recv_gap     = 0;
  logic              in_taken     = 1'b0;
  logic              out_taken    = 1'b0;
  logic              recv_block   = 1'b0;
  logic              no_idle      = 1'b0;
  event              recv_hold_start;

  // (price * factor) >> 30, saturated to all ones
  function automatic logic [btop_pkg::WORD_W-1:0] mul_q30(
      input logic [btop_pkg::WORD_W-1:0] price,
      input logic [btop_pkg::WORD_W-1:0] factor);
    logic [63:0] prod;
    prod = ({32'd0, price} * {32'd0, factor}) >> 30;
    return (prod[63:32] != 32'd0) ? '1 : prod[31:0];
  endfunction

  // weighted mix of two children, then one step of discounting
  function automatic logic [btop_pkg::WORD_W-1:0] fold_pair(
      input logic [btop_pkg::WORD_W-1:0] hi,
      input logic [btop_pkg::WORD_W-1:0] lo);
    logic [64:0] wt_up;
    logic [64:0] wt_dn;
    logic [64:0] mix;
    logic [63:0] scaled;
    wt_up  = {33'd0, market.prob};
    wt_dn  = (65'd1 << 32) - wt_up;
    mix    = (wt_up * {33'd0, hi} + wt_dn * {33'd0, lo}) >> 32;
    scaled = ({32'd0, mix[31:0]} * {32'd0, market.disc}) >> 32;
    return scaled[31:0];
  endfunction

  function automatic logic [btop_pkg::WORD_W-1:0] option_value(
      input logic [btop_pkg::WORD_W-1:0] spot,
      input logic                        put);
    logic [btop_pkg::WORD_W-1:0] node [btop_pkg::MAX_STEPS];
    logic [btop_pkg::WORD_W-1:0] px;
    int n;
    n = int'(market.steps);
    if (n < 1) n = 1;
    if (n > btop_pkg::MAX_STEPS) n = btop_pkg::MAX_STEPS;
    for (int j = 0; j < n; j++) begin
      px = spot;
      for (int k = 0; k < j; k++) px = mul_q30(px, market.up);
      for (int k = 0; k < n - 1 - j; k++) px = mul_q30(px, market.down);
      if (put) node[j] = (market.strike > px) ? market.strike - px : '0;
      else node[j] = (px > market.strike) ? px - market.strike : '0;
    end
    for (int lvl = n - 1; lvl >= 1; lvl--) begin
      for (int j = 0; j < lvl; j++) node[j] = fold_pair(node[j + 1], node[j]);
    end
    return node[0];
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [btop_pkg::WORD_W-1:0] pick_spot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return market.strike + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (r < 7) return $urandom_range(0, 32'h00FF_FFFF);
    return $urandom();
  endfunction

  task automatic write_reg(input logic [btop_pkg::CFG_IDX_W-1:0] idx,
                           input logic [btop_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    unique case (idx)
      btop_pkg::REG_UP:     market.up     = data;
      btop_pkg::REG_DOWN:   market.down   = data;
      btop_pkg::REG_PROB:   market.prob   = data;
      btop_pkg::REG_DISC:   market.disc   = data;
      btop_pkg::REG_STRIKE: market.strike = data;
      btop_pkg::REG_STEPS:  market.steps  = data[btop_pkg::STEPS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_quote(input logic [btop_pkg::WORD_W-1:0] spot, input logic put);
    quote_queue.insert(quote_queue.size(), '{spot: spot, put: put});
    quotes_sent++;
  endtask

  task automatic wait_settled();
    while (prices_seen < quotes_sent) @(negedge clk);
  endtask

  task automatic randomize_setup();
    logic [btop_pkg::STEPS_W-1:0] steps;
    int r;
    if ($urandom_range(0, 99) < 75) begin
      write_reg(btop_pkg::REG_UP,   32'h4000_0000 + $urandom_range(0, 32'h0400_0000));
      write_reg(btop_pkg::REG_DOWN, 32'h4000_0000 - $urandom_range(0, 32'h0400_0000));
      write_reg(btop_pkg::REG_PROB, $urandom_range(32'h6000_0000, 32'hA000_0000));
      write_reg(btop_pkg::REG_DISC, 32'hFFFF_FFFF - $urandom_range(0, 32'h0100_0000));
      write_reg(btop_pkg::REG_STRIKE, $urandom_range(32'h0001_0000, 32'h0400_0000));
    end else begin
      write_reg(btop_pkg::REG_UP,     $urandom());
      write_reg(btop_pkg::REG_DOWN,   $urandom());
      write_reg(btop_pkg::REG_PROB,   $urandom());
      write_reg(btop_pkg::REG_DISC,   $urandom());
      write_reg(btop_pkg::REG_STRIKE, $urandom());
    end
    r = $urandom_range(0, 99);
    if (r < 55) steps = btop_pkg::STEPS_W'($urandom_range(1, 12));
    else if (r < 82) steps = btop_pkg::STEPS_W'($urandom_range(13, 48));
    else if (r < 93) steps = btop_pkg::STEPS_W'($urandom_range(49, 128));
    else if (r < 97) steps = btop_pkg::STEPS_W'($urandom_range(200, 256));
    else steps = btop_pkg::STEPS_W'($urandom_range(0, 511));
    // upper data bits carry junk; only the low bits count
    write_reg(btop_pkg::REG_STEPS, ($urandom() & 32'hFFFF_FE00) | {23'd0, steps});
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    end
  endtask

  // input side: offer the next word once the current one is gone
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.spot_price <= '0;
      in_if.mode       <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (quote_queue.size() != 0) begin
        next_quote = quote_queue.pop_front();
        in_if.spot_price <= next_quote.spot;
        in_if.mode       <= next_quote.put;
        in_if.valid      <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus the long hold when requested
  always @(negedge clk) begin
    if (out_taken) recv_gap = pick_gap();
    if (!rst_n || recv_block) begin
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_if.ready <= 1'b0;
      recv_gap--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial forever begin
    @(recv_hold_start);
    @(posedge clk);
    recv_block = 1'b1;
    repeat (RECV_HOLD_CYCLES) @(posedge clk);
    recv_block = 1'b0;
  end

  // check results before predicting, so a word never meets its own expectation
  always @(posedge clk) begin
    in_taken  <= rst_n && in_if.valid && in_if.ready;
    out_taken <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      prices_seen++;
      if (price_expect.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected option price %h, expected none",
                 $time, out_if.option_price);
      end else begin
        expected_price = price_expect.pop_front();
        if (out_if.option_price !== expected_price) begin
          fail_count++;
          $display("%0t: option price mismatch, expected %h, got %h",
                   $time, expected_price, out_if.option_price);
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready)
      price_expect.insert(price_expect.size(),
                          option_value(in_if.spot_price, in_if.mode));
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int batch;
    int pause_at;
    int random_count;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    market.up     = btop_pkg::UP_RST;
    market.down   = btop_pkg::DOWN_RST;
    market.prob   = btop_pkg::PROB_RST;
    market.disc   = btop_pkg::DISC_RST;
    market.strike = btop_pkg::STRIKE_RST;
    market.steps  = btop_pkg::STEPS_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: full tree, unit factors, zero strike
    queue_quote('0, MODE_CALL);
    queue_quote('1, MODE_PUT);
    queue_quote(32'h0001_0000, MODE_CALL);
    wait_settled();

    // single leaf; writes to unused indexes must change nothing
    write_reg(btop_pkg::REG_STEPS, 32'hABCD_FE01);
    write_reg(btop_pkg::REG_STRIKE, 32'h0010_0000);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    queue_quote(32'h0020_0000, MODE_CALL);
    queue_quote(32'h0020_0000, MODE_PUT);
    queue_quote('1, MODE_CALL);
    queue_quote('0, MODE_PUT);
    wait_settled();

    // zero steps behave as one leaf; full-scale strike
    write_reg(btop_pkg::REG_STEPS, '0);
    write_reg(btop_pkg::REG_STRIKE, '1);
    queue_quote(32'd5, MODE_PUT);
    queue_quote(32'd5, MODE_CALL);
    wait_settled();

    // saturating up move, zero down move, zero probability
    write_reg(btop_pkg::REG_UP, '1);
    write_reg(btop_pkg::REG_DOWN, '0);
    write_reg(btop_pkg::REG_PROB, '0);
    write_reg(btop_pkg::REG_DISC, '1);
    write_reg(btop_pkg::REG_STRIKE, 32'd1);
    write_reg(btop_pkg::REG_STEPS, 32'd2);
    queue_quote('1, MODE_CALL);
    queue_quote('1, MODE_PUT);
    queue_quote(32'd1, MODE_CALL);
    wait_settled();

    // zero up move, full-scale down and probability, zero discount
    write_reg(btop_pkg::REG_UP, '0);
    write_reg(btop_pkg::REG_DOWN, '1);
    write_reg(btop_pkg::REG_PROB, '1);
    write_reg(btop_pkg::REG_DISC, '0);
    write_reg(btop_pkg::REG_STEPS, 32'd3);
    queue_quote(32'h1234_5678, MODE_CALL);
    queue_quote(32'h1234_5678, MODE_PUT);
    wait_settled();

    // step count above the tree size clamps to the full tree
    write_reg(btop_pkg::REG_UP, 32'h4100_0000);
    write_reg(btop_pkg::REG_DOWN, 32'h3F00_0000);
    write_reg(btop_pkg::REG_PROB, 32'h8100_0000);
    write_reg(btop_pkg::REG_DISC, 32'hFFF0_0000);
    write_reg(btop_pkg::REG_STRIKE, 32'h0064_0000);
    write_reg(btop_pkg::REG_STEPS, 32'd511);
    queue_quote(32'h0064_0000, MODE_CALL);
    queue_quote(32'h0060_0000, MODE_PUT);
    wait_settled();

    // hold the result side long enough for the input to back up
    randomize_setup();
    write_reg(btop_pkg::REG_STEPS, 32'd4);
    -> recv_hold_start;
    for (int k = 0; k < PRESSURE_QUOTES; k++) queue_quote(pick_spot(), 1'($urandom_range(0, 1)));
    wait_settled();

    random_count = 0;
    while (random_count < RANDOM_QUOTES) begin
      randomize_setup();
      no_idle  = ($urandom_range(0, 4) == 0);
      batch    = (market.steps > 64) ? $urandom_range(2, 6) : $urandom_range(5, 25);
      pause_at = ($urandom_range(0, 3) == 0) ? batch / 2 : -1;
      for (int k = 0; k < batch; k++) begin
        // drain completely mid-phase now and then
        if (k == pause_at) wait_settled();
        queue_quote(pick_spot(), 1'($urandom_range(0, 1)));
      end
      random_count += batch;
      wait_settled();
    end
    no_idle = 1'b0;

    wait_settled();
    repeat (END_WAIT) @(negedge clk);
    if (price_expect.size() != 0) begin
      fail_count++;
      $display("%0t: %0d option prices never arrived", $time, price_expect.size());
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
